### design/cftp_pkg.sv
// Package for the CAN text frame parser: result type, character codes,
// default parameter values and the hex digit decode. No dependencies.
package cftp_pkg;

    // Default number of payload bytes a frame may carry.
    localparam int MAX_DATA_BYTES_DEF = 8;

    // Field widths of one result transfer.
    localparam int ID_W       = 29;
    localparam int COUNT_W    = 4;
    localparam int PAYLOAD_W  = 64;
    localparam int OUT_BYTES  = PAYLOAD_W / 8;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_OUT_W = 104;

    // Characters with a special meaning in the text stream.
    localparam logic [7:0] CHAR_START = 8'h53;  // 'S'
    localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHAR_NEG   = 8'h80;  // first byte read as negative
    localparam logic [7:0] LETTER_ADJ = 8'h07;  // gap between '9' and 'A'
    localparam logic [ID_W-1:0] STD_ID_MAX = 29'h7FF;

    // One parsed frame.
    typedef struct packed {
        logic                 overflow;
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   byte_count;
        logic                 extended;
        logic [ID_W-1:0]      can_id;
    } result_t;

    // Hex digit decode: letters are pulled down by seven, then the low
    // nibble is kept. Negative bytes keep their own low nibble.
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] adj;
        adj = b;
        if (b > CHAR_NINE && b < CHAR_NEG) begin
            adj = b - LETTER_ADJ;
        end
        return adj[3:0];
    endfunction

endpackage

### design/cftp_in_stage.sv
// Input register of the CAN text frame parser: holds one received byte
// until the parser takes it. Depends on cftp_pkg.
module cftp_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cftp_pkg::TDATA_IN_W-1:0] s_tdata,
    input  logic                            advance,
    output logic                            byte_valid,
    output logic [7:0]                      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // A new byte may enter when the register is empty or is being drained.
    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    // Valid flag is reset; the byte itself needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_tdata[7:0];
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

### design/cftp_parser.sv
// Parser core of the CAN text frame parser: phase, identifier, digit count
// and payload bytes, updated once per byte. Depends on cftp_pkg.
module cftp_parser #(
    parameter int MAX_DATA_BYTES = cftp_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  logic              advance,
    output logic              emit,
    output cftp_pkg::result_t result
);

    // Only the bytes that reach the output are stored; later ones are
    // never observable.
    localparam int STORE = (MAX_DATA_BYTES < cftp_pkg::OUT_BYTES) ?
                           MAX_DATA_BYTES : cftp_pkg::OUT_BYTES;
    localparam int NIB_W = $clog2(2 * MAX_DATA_BYTES + 1);
    localparam int HALF_W = NIB_W + 4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]                  phase_reg, phase_next;
    logic [cftp_pkg::ID_W-1:0]   id_reg, id_next;
    logic [NIB_W-1:0]            nib_reg, nib_next;
    logic                        ovf_reg, ovf_next;
    logic [7:0]                  bytes_reg  [STORE];
    logic [7:0]                  bytes_next [STORE];
    logic [3:0]                  nibble;
    logic                        is_digit;
    logic [HALF_W-1:0]           half_wide;

    assign nibble   = cftp_pkg::hex_nibble(byte_data);
    assign is_digit = (byte_data >= cftp_pkg::CHAR_ZERO) && (byte_data < cftp_pkg::CHAR_NEG);

    // Next-state logic for one byte.
    always_comb begin
        phase_next = phase_reg;
        id_next    = id_reg;
        nib_next   = nib_reg;
        ovf_next   = ovf_reg;
        for (int i = 0; i < STORE; i++) begin
            bytes_next[i] = bytes_reg[i];
        end
        unique case (phase_reg)
            PH_ID: begin
                if (byte_data == cftp_pkg::CHAR_HASH) begin
                    phase_next = PH_DATA;
                    nib_next   = '0;
                    ovf_next   = 1'b0;
                end else begin
                    id_next = {id_reg[cftp_pkg::ID_W-5:0], nibble};
                end
            end
            PH_DATA: begin
                if (is_digit) begin
                    if (nib_reg < NIB_W'(2 * MAX_DATA_BYTES)) begin
                        // Shift the digit into the byte that this pair belongs to.
                        for (int i = 0; i < STORE; i++) begin
                            if (nib_reg[NIB_W-1:1] == (NIB_W-1)'(i)) begin
                                bytes_next[i] = {bytes_reg[i][3:0], nibble};
                            end
                        end
                        nib_next = NIB_W'(nib_reg + 1'b1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                if (byte_data == cftp_pkg::CHAR_START) begin
                    phase_next = PH_ID;
                    id_next    = '0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // State registers, stepped once per byte taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            id_reg    <= '0;
            nib_reg   <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < STORE; i++) begin
                bytes_reg[i] <= '0;
            end
        end else if (advance) begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            nib_reg   <= nib_next;
            ovf_reg   <= ovf_next;
            for (int i = 0; i < STORE; i++) begin
                bytes_reg[i] <= bytes_next[i];
            end
        end
    end

    // A byte below '0' in the data phase closes the frame.
    assign emit = byte_valid && (phase_reg == PH_DATA) && !is_digit;

    // Result fields, built from the state before the closing byte.
    assign half_wide = HALF_W'(nib_reg >> 1);

    always_comb begin
        result.can_id     = id_reg;
        result.extended   = (id_reg > cftp_pkg::STD_ID_MAX);
        result.byte_count = (half_wide > HALF_W'(cftp_pkg::OUT_BYTES)) ?
                            cftp_pkg::COUNT_W'(cftp_pkg::OUT_BYTES) :
                            half_wide[cftp_pkg::COUNT_W-1:0];
        result.overflow   = ovf_reg;
        // Bytes beyond the stored ones read as zero.
        result.payload    = '0;
        for (int i = 0; i < STORE; i++) begin
            result.payload[8*i +: 8] = bytes_reg[i];
        end
    end

endmodule

### design/cftp_out_stage.sv
// Result register of the CAN text frame parser: holds one parsed frame
// until the receiver takes it. Depends on cftp_pkg.
module cftp_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  cftp_pkg::result_t                result,
    output logic                             out_free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cftp_pkg::TDATA_OUT_W-1:0] m_tdata
);

    localparam int RES_W = $bits(cftp_pkg::result_t);

    logic              valid_reg;
    logic              valid_next;
    cftp_pkg::result_t data_reg;

    // The register can take a new frame when empty or being drained.
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(cftp_pkg::TDATA_OUT_W - RES_W){1'b0}}, data_reg};

endmodule

### design/can_frame_text_parser_unit.sv
// CAN text frame parser, top level. Joins input register, parser core and
// result register. Depends on cftp_pkg, cftp_in_stage, cftp_parser and cftp_out_stage.
//
// Usage:
//   The s_ channel carries one ASCII byte per transfer. Frames are written
//   as 'S', hex identifier digits, '#', hex data digits, and are closed by
//   any byte below '0' (bytes 0x80-0xFF count as below '0'). Each closed
//   frame gives one transfer on the m_ channel with identifier, extended
//   flag, byte count, eight payload bytes and a digit overflow flag.
//   Throughput is one byte per cycle while no closing byte waits for a busy
//   result register. A closing byte is first held in the input register and
//   then loaded into the result register, whose valid flag drives m_tvalid.
//   When the receiver stalls, the result register holds its frame; bytes
//   that do not close a frame keep flowing, and a closing byte waits in the
//   input register until the result register is free, with s_tready low meanwhile.
//   A synchronous reset (aresetn low) empties both registers, returns the
//   parser to waiting for 'S' and clears the identifier, digit count,
//   payload bytes and overflow flag.
module can_frame_text_parser_unit #(
    parameter int MAX_DATA_BYTES = cftp_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: char_in [7:0]
    input  logic [cftp_pkg::TDATA_IN_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: can_id [28:0], extended [29], byte_count [33:30],
    //          payload [97:34], overflow [98], zero fill [103:99]
    output logic [cftp_pkg::TDATA_OUT_W-1:0] m_tdata
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              emit;
    logic              out_free;
    logic              advance;
    cftp_pkg::result_t result;

    // A held byte moves on unless it closes a frame and the result is blocked.
    assign advance = byte_valid && (!emit || out_free);

    cftp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    cftp_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance),
        .emit       (emit),
        .result     (result)
    );

    cftp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The extended flag always agrees with the identifier it travels with.
    a_ext_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29] == (m_tdata[28:0] > 29'h7FF)))
        else $error("extended flag does not match identifier");

    // The byte count never exceeds eight.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:30] <= 4'd8))
        else $error("byte count above eight");

    // A result appears only after a closing byte was passed on.
    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance && emit))
        else $error("result appeared without a closing byte");

    // An input transfer always lands in the input register.
    a_in_land: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> byte_valid)
        else $error("accepted byte lost");

endmodule
